FILE: rtl/core/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache LRU package
// Shared sizes, entry layout, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int ENTRIES = 128;
    localparam int AW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);

    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int IDX_W   = 7;
    localparam int TICK_W  = 32;
    localparam int CNT_W   = 8;
    localparam int SLOT_W  = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef logic [AW-1:0]     t_addr;
    typedef logic [CW-1:0]     t_cnt;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT_WR,
        S_MISS_WR,
        S_REL_RD,
        S_REL_WR
    } t_state;

    // One tag table entry as stored in the RAM.
    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [DEV_W-1:0]  dev;
        logic [CNT_W-1:0]  cnt;
        logic [TICK_W-1:0] tick;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              op;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [IDX_W-1:0]  entry_index;
        logic [TICK_W-1:0] now_tick;
    } t_req;

    typedef struct packed {
        logic start;
        logic scan;
        logic hit_wr;
        logic miss_wr;
        logic rel_rd;
        logic rel_wr;
    } t_cmd;

    typedef struct packed {
        logic in_op;
        logic match;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/bbc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache request channel
// Valid/ready channel carrying one acquire or release request.
// ----------------------------------------------------------------------------
interface bbc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [bbc_pkg::DEV_W-1:0]  device;
    logic [bbc_pkg::BLK_W-1:0]  block_number;
    logic [bbc_pkg::IDX_W-1:0]  entry_index;
    logic [bbc_pkg::TICK_W-1:0] now_tick;

    modport source (
        output valid, op, device, block_number, entry_index, now_tick,
        input  ready
    );
    modport sink (
        input  valid, op, device, block_number, entry_index, now_tick,
        output ready
    );
endinterface

FILE: rtl/core/bbc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bbc_pkg::SLOT_W-1:0] slot;
    logic                       hit;
    logic                       need_fill;
    logic [1:0]                 status;

    modport source (
        output valid, slot, hit, need_fill, status,
        input  ready
    );
    modport sink (
        input  valid, slot, hit, need_fill, status,
        output ready
    );
endinterface

FILE: rtl/core/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache controller
// Sequences the table scan, the entry update and the release path.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bbc_pkg::t_stat  i_stat,
    output bbc_pkg::t_cmd   o_cmd
);

    bbc_pkg::t_state r_state;
    bbc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bbc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_stat.in_op == bbc_pkg::OP_RELEASE) begin
                        n_state = bbc_pkg::S_REL_RD;
                    end else begin
                        n_state = bbc_pkg::S_SCAN;
                    end
                end
            end
            bbc_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.match) begin
                    n_state = bbc_pkg::S_HIT_WR;
                end else if (i_stat.scan_last) begin
                    n_state = bbc_pkg::S_MISS_WR;
                end
            end
            bbc_pkg::S_HIT_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.hit_wr = 1'b1;
                    n_state      = bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_MISS_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.miss_wr = 1'b1;
                    n_state       = bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_REL_RD: begin
                o_cmd.rel_rd = 1'b1;
                n_state      = bbc_pkg::S_REL_WR;
            end
            bbc_pkg::S_REL_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.rel_wr = 1'b1;
                    n_state      = bbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/bbc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache datapath
// Tag RAM, entry valid bits, scan pipeline, LRU tracker and result register.
// ----------------------------------------------------------------------------
module bbc_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bbc_pkg::t_req    i_req,
    input  bbc_pkg::t_cmd    i_cmd,
    output bbc_pkg::t_stat   o_stat,
    bbc_rsp_if.source        o_rsp
);

    // Latched request.
    logic [bbc_pkg::DEV_W-1:0]  r_dev;
    logic [bbc_pkg::BLK_W-1:0]  r_blk;
    logic [bbc_pkg::IDX_W-1:0]  r_eidx;
    logic [bbc_pkg::TICK_W-1:0] r_now;

    // Scan pipeline.
    bbc_pkg::t_cnt  r_scan_cnt;
    logic           r_cmp_vld;
    bbc_pkg::t_addr r_cmp_idx;
    logic           r_rd_valid;

    // Hit capture and oldest free entry.
    bbc_pkg::t_addr              r_hit_idx;
    bbc_pkg::t_entry             r_hit_word;
    logic                        r_have_free;
    bbc_pkg::t_addr              r_old_idx;
    logic [bbc_pkg::TICK_W-1:0]  r_old_tick;

    logic [bbc_pkg::ENTRIES-1:0] r_valid;

    // Result register.
    logic                        r_out_vld;
    bbc_pkg::t_slot              r_out_slot;
    logic                        r_out_hit;
    logic                        r_out_fill;
    bbc_pkg::t_status            r_out_status;

    logic                          scan_rd;
    logic                          rd_en;
    bbc_pkg::t_addr                rd_addr;
    bbc_pkg::t_addr                rel_addr;
    logic [bbc_pkg::ENTRY_W-1:0]   ram_q;
    bbc_pkg::t_entry               rd_word;
    logic                          match;
    logic                          free_better;
    logic                          rel_in_range;
    logic                          wr_en;
    bbc_pkg::t_addr                wr_addr;
    bbc_pkg::t_entry               wr_word;
    logic                          res_load;
    bbc_pkg::t_slot                res_slot;
    logic                          res_hit;
    logic                          res_fill;
    bbc_pkg::t_status              res_status;

    assign rel_addr = bbc_pkg::t_addr'(r_eidx);
    assign scan_rd  = i_cmd.scan && (r_scan_cnt < bbc_pkg::t_cnt'(bbc_pkg::ENTRIES));
    assign rd_en    = scan_rd || i_cmd.rel_rd;
    assign rd_addr  = i_cmd.rel_rd ? rel_addr : r_scan_cnt[bbc_pkg::AW-1:0];

    bbc_ram #(
        .WIDTH (bbc_pkg::ENTRY_W),
        .DEPTH (bbc_pkg::ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // An entry that was never written reads as all zero.
    assign rd_word = r_rd_valid ? bbc_pkg::t_entry'(ram_q) : '0;

    assign match = r_cmp_vld && r_rd_valid && (rd_word.dev == r_dev) &&
                   (rd_word.blk == r_blk);
    assign free_better = r_cmp_vld && (rd_word.cnt == '0) &&
                         (!r_have_free || (rd_word.tick < r_old_tick));

    assign rel_in_range = 32'(r_eidx) < 32'(bbc_pkg::ENTRIES);

    assign o_stat.in_op     = i_req.op;
    assign o_stat.match     = match;
    assign o_stat.scan_last = r_cmp_vld &&
                              (r_cmp_idx == bbc_pkg::t_addr'(bbc_pkg::ENTRIES - 1));
    assign o_stat.out_free  = !r_out_vld || o_rsp.ready;

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_hit_idx;
        wr_word    = r_hit_word;
        res_load   = 1'b0;
        res_slot   = '0;
        res_hit    = 1'b0;
        res_fill   = 1'b0;
        res_status = bbc_pkg::ST_OK;
        if (i_cmd.hit_wr) begin
            wr_en        = 1'b1;
            wr_word.tick = r_now;
            res_load     = 1'b1;
            res_slot     = bbc_pkg::t_slot'(r_hit_idx);
            res_hit      = 1'b1;
            if (r_hit_word.cnt == bbc_pkg::CNT_MAX) begin
                res_status = bbc_pkg::ST_OVERFLOW;
            end else begin
                wr_word.cnt = r_hit_word.cnt + bbc_pkg::CNT_ONE;
            end
        end else if (i_cmd.miss_wr) begin
            res_load = 1'b1;
            wr_addr  = r_old_idx;
            wr_word  = '{blk: r_blk, dev: r_dev, cnt: bbc_pkg::CNT_ONE, tick: r_now};
            if (r_have_free) begin
                wr_en    = 1'b1;
                res_slot = bbc_pkg::t_slot'(r_old_idx);
                res_fill = 1'b1;
            end else begin
                res_status = bbc_pkg::ST_NO_FREE;
            end
        end else if (i_cmd.rel_wr) begin
            res_load = 1'b1;
            res_slot = bbc_pkg::t_slot'(r_eidx);
            wr_addr  = rel_addr;
            wr_word  = rd_word;
            if (rel_in_range) begin
                if (rd_word.cnt == '0) begin
                    res_status = bbc_pkg::ST_UNDERFLOW;
                end else begin
                    wr_en       = 1'b1;
                    wr_word.cnt = rd_word.cnt - bbc_pkg::CNT_ONE;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cmp_vld <= scan_rd;
            if (i_cmd.miss_wr && r_have_free) begin
                r_valid[r_old_idx] <= 1'b1;
            end
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dev       <= i_req.device;
            r_blk       <= i_req.block_number;
            r_eidx      <= i_req.entry_index;
            r_now       <= i_req.now_tick;
            r_scan_cnt  <= '0;
            r_have_free <= 1'b0;
        end
        if (scan_rd) begin
            r_scan_cnt <= r_scan_cnt + bbc_pkg::t_cnt'(1);
        end
        if (rd_en) begin
            r_cmp_idx  <= rd_addr;
            r_rd_valid <= r_valid[rd_addr];
        end
        if (i_cmd.scan && match) begin
            r_hit_idx  <= r_cmp_idx;
            r_hit_word <= rd_word;
        end else if (i_cmd.scan && free_better) begin
            r_have_free <= 1'b1;
            r_old_idx   <= r_cmp_idx;
            r_old_tick  <= rd_word.tick;
        end
        if (res_load) begin
            r_out_slot   <= res_slot;
            r_out_hit    <= res_hit;
            r_out_fill   <= res_fill;
            r_out_status <= res_status;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.slot      = r_out_slot;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.need_fill = r_out_fill;
    assign o_rsp.status    = r_out_status;

endmodule

FILE: rtl/core/block_buffer_cache_lru_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block buffer cache LRU tag table
// Acquire: one entry read per cycle from the single-read-port tag RAM. On a miss
// the whole table is scanned before the response; a hit ends the scan at its entry.
// Release: the indexed entry is read, then, if held, written back with its count
// lowered. One request in flight; a stalled response holds the controller.
// Synchronous reset clears all entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbc_req_if.sink     i_req,
    bbc_rsp_if.source   o_rsp
);

    bbc_pkg::t_cmd  cmd;
    bbc_pkg::t_stat stat;
    bbc_pkg::t_req  req;

    assign req.op           = i_req.op;
    assign req.device       = i_req.device;
    assign req.block_number = i_req.block_number;
    assign req.entry_index  = i_req.entry_index;
    assign req.now_tick     = i_req.now_tick;

    bbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bbc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache LRU tag table testbench
// Drives acquire and release requests through bursty traffic with a stalling
// response side, predicts each grant with a model of the tag table or takes it
// from the directed plan, and checks each response field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PLAN_ROWS      = 22;
    localparam int RANDOM_ITEMS   = 400;
    localparam int POOL_KEYS      = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        bbc_pkg::t_slot   slot;
        logic             hit;
        logic             need_fill;
        bbc_pkg::t_status status;
    } t_grant;

    // One row of the directed plan. A row with count above one repeats its
    // request; with walk set, block number and tick step on each repeat.
    typedef struct packed {
        logic                       op;
        logic [bbc_pkg::DEV_W-1:0]  device;
        logic [bbc_pkg::BLK_W-1:0]  block_number;
        logic [bbc_pkg::IDX_W-1:0]  entry_index;
        logic [bbc_pkg::TICK_W-1:0] now_tick;
        logic [8:0]                 count;
        logic                       walk;
        logic                       typed;
        t_grant                     want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbc_req_if req_ch ();
    bbc_rsp_if rsp_ch ();

    block_buffer_cache_lru_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted tag table.
    logic [bbc_pkg::BLK_W-1:0]  tbl_blk   [bbc_pkg::ENTRIES];
    logic [bbc_pkg::DEV_W-1:0]  tbl_dev   [bbc_pkg::ENTRIES];
    logic [bbc_pkg::CNT_W-1:0]  tbl_cnt   [bbc_pkg::ENTRIES];
    logic [bbc_pkg::TICK_W-1:0] tbl_tick  [bbc_pkg::ENTRIES];
    logic                       tbl_valid [bbc_pkg::ENTRIES];

    t_grant            expected_grants [$];
    int                error_count = 0;
    t_plan_row         plan [PLAN_ROWS];

    logic [bbc_pkg::DEV_W-1:0]  pool_dev [POOL_KEYS];
    logic [bbc_pkg::BLK_W-1:0]  pool_blk [POOL_KEYS];
    logic [bbc_pkg::TICK_W-1:0] tick_now;
    bit                         fill_mode;

    function automatic t_grant tag_table_lookup(input bbc_pkg::t_req r);
        t_grant g;
        int     i;
        int     oldest;
        bit     have_free;
        bit     done;
        g = '0;
        g.status = bbc_pkg::ST_OK;
        if (r.op == bbc_pkg::OP_RELEASE) begin
            g.slot = bbc_pkg::t_slot'(r.entry_index);
            if (int'(r.entry_index) < bbc_pkg::ENTRIES) begin
                if (tbl_cnt[r.entry_index] == '0) begin
                    g.status = bbc_pkg::ST_UNDERFLOW;
                end else begin
                    tbl_cnt[r.entry_index] = tbl_cnt[r.entry_index] - bbc_pkg::CNT_ONE;
                end
            end
            return g;
        end
        have_free = 1'b0;
        done = 1'b0;
        oldest = 0;
        for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
            if (!done) begin
                if (tbl_valid[i] && tbl_dev[i] == r.device &&
                    tbl_blk[i] == r.block_number) begin
                    g.slot = bbc_pkg::t_slot'(i);
                    g.hit = 1'b1;
                    if (tbl_cnt[i] == bbc_pkg::CNT_MAX) begin
                        g.status = bbc_pkg::ST_OVERFLOW;
                    end else begin
                        tbl_cnt[i] = tbl_cnt[i] + bbc_pkg::CNT_ONE;
                    end
                    tbl_tick[i] = r.now_tick;
                    done = 1'b1;
                end else if (tbl_cnt[i] == '0 &&
                             (!have_free || tbl_tick[i] < tbl_tick[oldest])) begin
                    have_free = 1'b1;
                    oldest = i;
                end
            end
        end
        if (done) begin
            return g;
        end
        if (!have_free) begin
            g.status = bbc_pkg::ST_NO_FREE;
            return g;
        end
        tbl_blk[oldest]   = r.block_number;
        tbl_dev[oldest]   = r.device;
        tbl_cnt[oldest]   = bbc_pkg::CNT_ONE;
        tbl_tick[oldest]  = r.now_tick;
        tbl_valid[oldest] = 1'b1;
        g.slot = bbc_pkg::t_slot'(oldest);
        g.need_fill = 1'b1;
        return g;
    endfunction

    // Mostly acquires from a small working set and releases of held entries,
    // so that hits, reuse and eviction order all get exercised. Release odds
    // rise with occupancy unless the table is being pushed toward full.
    function automatic bbc_pkg::t_req make_random_request();
        bbc_pkg::t_req r;
        int   i;
        int   held;
        int   start;
        int   rel_pct;
        int   fresh_pct;
        int   k;
        bit   found;
        held = 0;
        for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
            if (tbl_cnt[i] != '0) begin
                held++;
            end
        end
        rel_pct   = fill_mode ? 10 : 20 + (60 * held) / bbc_pkg::ENTRIES;
        fresh_pct = fill_mode ? 70 : 25;
        tick_now  = tick_now + bbc_pkg::TICK_W'($urandom_range(0, 3));
        r.op           = bbc_pkg::OP_ACQUIRE;
        r.device       = bbc_pkg::DEV_W'($urandom);
        r.block_number = bbc_pkg::BLK_W'($urandom);
        r.entry_index  = bbc_pkg::IDX_W'($urandom);
        r.now_tick     = ($urandom_range(0, 19) == 0) ? bbc_pkg::TICK_W'($urandom)
                                                      : tick_now;
        if ($urandom_range(0, 99) < rel_pct) begin
            r.op = bbc_pkg::OP_RELEASE;
            if (held > 0 && $urandom_range(0, 99) < 85) begin
                start = $urandom_range(0, bbc_pkg::ENTRIES - 1);
                found = 1'b0;
                for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
                    k = (start + i) % bbc_pkg::ENTRIES;
                    if (!found && tbl_cnt[k] != '0) begin
                        r.entry_index = bbc_pkg::IDX_W'(k);
                        found = 1'b1;
                    end
                end
            end
        end else if ($urandom_range(0, 99) >= fresh_pct) begin
            k = $urandom_range(0, POOL_KEYS - 1);
            r.device       = pool_dev[k];
            r.block_number = pool_blk[k];
        end
        return r;
    endfunction

    // Response side: checks in order and stalls on a rotating pattern that is
    // redrawn now and then; some patterns never stall.
    logic [15:0] stall_pat = 16'hFFFF;
    int          stall_age = 0;

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: response with no request outstanding: slot %0d status %0d",
                         $time, rsp_ch.slot, rsp_ch.status);
                error_count++;
            end else begin
                want = expected_grants.pop_front();
                if (rsp_ch.slot !== want.slot || rsp_ch.hit !== want.hit ||
                    rsp_ch.need_fill !== want.need_fill ||
                    rsp_ch.status !== want.status) begin
                    $display("%0t: expected slot %0d hit %0b fill %0b status %0d, got slot %0d hit %0b fill %0b status %0d",
                             $time, want.slot, want.hit, want.need_fill, want.status,
                             rsp_ch.slot, rsp_ch.hit, rsp_ch.need_fill, rsp_ch.status);
                    error_count++;
                end
            end
        end
        if (stall_age == 0) begin
            stall_age = $urandom_range(20, 200);
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end else begin
            stall_age--;
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
        rsp_ch.ready <= i_rst_n && stall_pat[0];
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        bbc_pkg::t_req cur;
        t_grant        cur_want;
        t_grant        got;
        t_plan_row     row;
        bit            cur_typed;
        bit            presenting;
        bit            more;
        int            gap_left;
        int            burst_left;
        int            plan_pos;
        int            plan_rep;
        int            rand_made;
        int            i;

        plan = '{
            // Release of a never-held entry, at both ends of the table.
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd0, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_UNDERFLOW}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd127, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd127, 1'b0, 1'b0, bbc_pkg::ST_UNDERFLOW}},
            // Zero tags of a never-used entry must not match a zero request.
            '{bbc_pkg::OP_ACQUIRE, 8'h00, 32'h0000_0000, 7'd0, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b0, 1'b1, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_ACQUIRE, 8'h00, 32'h0000_0000, 7'd0, 32'd5, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b1, 1'b0, bbc_pkg::ST_OK}},
            // Same block on another device is a different block.
            '{bbc_pkg::OP_ACQUIRE, 8'h01, 32'h0000_0000, 7'd0, 32'd6, 9'd1, 1'b0, 1'b1,
              '{7'd1, 1'b0, 1'b1, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 7'h7F, 32'hFFFF_FFFF, 9'd1,
              1'b0, 1'b1, '{7'd2, 1'b0, 1'b1, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd0, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd0, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd0, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_UNDERFLOW}},
            // A free entry that still holds its tags is a hit.
            '{bbc_pkg::OP_ACQUIRE, 8'h00, 32'h0000_0000, 7'd0, 32'd7, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b1, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd1, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd1, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            // Entry 1 is free but newer than the untouched ones.
            '{bbc_pkg::OP_ACQUIRE, 8'h5A, 32'h1234_5678, 7'd0, 32'd8, 9'd1, 1'b0, 1'b1,
              '{7'd3, 1'b0, 1'b1, bbc_pkg::ST_OK}},
            // Count entry 3 up to its limit, then past it.
            '{bbc_pkg::OP_ACQUIRE, 8'h5A, 32'h1234_5678, 7'd0, 32'd9, 9'd254, 1'b0, 1'b0,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_ACQUIRE, 8'h5A, 32'h1234_5678, 7'd0, 32'd10, 9'd1, 1'b0, 1'b1,
              '{7'd3, 1'b1, 1'b0, bbc_pkg::ST_OVERFLOW}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd3, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd3, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            // Fill every free entry, then ask for one more.
            '{bbc_pkg::OP_ACQUIRE, 8'hA5, 32'h8000_0000, 7'd0, 32'd100, 9'd125, 1'b1, 1'b0,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_ACQUIRE, 8'h11, 32'hDEAD_BEEF, 7'd0, 32'd300, 9'd1, 1'b0, 1'b1,
              '{7'd0, 1'b0, 1'b0, bbc_pkg::ST_NO_FREE}},
            '{bbc_pkg::OP_ACQUIRE, 8'hA5, 32'h8000_0000, 7'd0, 32'd301, 9'd1, 1'b0, 1'b1,
              '{7'd4, 1'b1, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd127, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd127, 1'b0, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_ACQUIRE, 8'h11, 32'hDEAD_BEEF, 7'd0, 32'd302, 9'd1, 1'b0, 1'b1,
              '{7'd127, 1'b0, 1'b1, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_ACQUIRE, 8'h11, 32'hDEAD_BEEF, 7'd0, 32'd303, 9'd1, 1'b0, 1'b1,
              '{7'd127, 1'b1, 1'b0, bbc_pkg::ST_OK}},
            '{bbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 7'd64, 32'd0, 9'd1, 1'b0, 1'b1,
              '{7'd64, 1'b0, 1'b0, bbc_pkg::ST_OK}}
        };

        for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
            tbl_blk[i]   = '0;
            tbl_dev[i]   = '0;
            tbl_cnt[i]   = '0;
            tbl_tick[i]  = '0;
            tbl_valid[i] = 1'b0;
        end
        // Pairs of working-set keys share a block number; each key draws its own device.
        for (i = 0; i < POOL_KEYS; i++) begin
            pool_dev[i] = bbc_pkg::DEV_W'($urandom);
            pool_blk[i] = (i % 2 == 1) ? pool_blk[i - 1] : bbc_pkg::BLK_W'($urandom);
        end
        tick_now  = bbc_pkg::TICK_W'(1000);
        fill_mode = 1'b0;

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = bbc_pkg::OP_ACQUIRE;
        req_ch.device       = '0;
        req_ch.block_number = '0;
        req_ch.entry_index  = '0;
        req_ch.now_tick     = '0;
        rsp_ch.ready        = 1'b0;
        cur        = '0;
        cur_want   = '0;
        cur_typed  = 1'b0;
        presenting = 1'b0;
        more       = 1'b1;
        gap_left   = 0;
        burst_left = 1;
        plan_pos   = 0;
        plan_rep   = 0;
        rand_made  = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (more || presenting) begin
            @(posedge i_clk);
            if (req_ch.valid && req_ch.ready) begin
                got = tag_table_lookup(cur);
                expected_grants.push_back(cur_typed ? cur_want : got);
                presenting = 1'b0;
            end
            if (!presenting && gap_left > 0) begin
                gap_left--;
            end else if (!presenting && more) begin
                if (plan_pos < PLAN_ROWS) begin
                    row = plan[plan_pos];
                    cur.op           = row.op;
                    cur.device       = row.device;
                    cur.entry_index  = row.entry_index;
                    cur.block_number = row.block_number +
                                       (row.walk ? bbc_pkg::BLK_W'(plan_rep) : '0);
                    cur.now_tick     = row.now_tick +
                                       (row.walk ? bbc_pkg::TICK_W'(plan_rep) : '0);
                    cur_typed  = row.typed;
                    cur_want   = row.want;
                    presenting = 1'b1;
                    plan_rep++;
                    if (plan_rep == int'(row.count)) begin
                        plan_pos++;
                        plan_rep = 0;
                    end
                end else if (rand_made < RANDOM_ITEMS) begin
                    if (rand_made % 100 == 0) begin
                        fill_mode = ($urandom_range(0, 2) == 0);
                    end
                    cur        = make_random_request();
                    cur_typed  = 1'b0;
                    presenting = 1'b1;
                    rand_made++;
                end else begin
                    more = 1'b0;
                end
                if (presenting) begin
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 7))
                            0, 1, 2: gap_left = 0;
                            3, 4, 5: gap_left = $urandom_range(1, 8);
                            6:       gap_left = $urandom_range(20, 60);
                            default: gap_left = $urandom_range(100, 300);
                        endcase
                    end
                end
            end
            req_ch.valid        <= presenting;
            req_ch.op           <= cur.op;
            req_ch.device       <= cur.device;
            req_ch.block_number <= cur.block_number;
            req_ch.entry_index  <= cur.entry_index;
            req_ch.now_tick     <= cur.now_tick;
        end

        while (expected_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bbc_pkg.sv
rtl/core/bbc_req_if.sv
rtl/core/bbc_rsp_if.sv
rtl/core/bbc_ram.sv
rtl/core/bbc_ctrl.sv
rtl/core/bbc_dpath.sv
rtl/core/block_buffer_cache_lru_unit.sv
tb/sv/testbench.sv
